// ===== rtl/concentric_disk_sampler_assert.svh =====
// Assertion macros for the concentric disk sampler.
// Used by the top-level module; no other dependencies.
`ifndef CONCENTRIC_DISK_SAMPLER_ASSERT_SVH
`define CONCENTRIC_DISK_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define CDS_ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define CDS_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CDS_ASSERT_IMPL(label, clk, rstn, a, c)
`define CDS_ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

// ===== rtl/cds_pkg.sv =====
// Package for the concentric disk sampler: constants and the arctangent table.
// No dependencies.
package cds_pkg;
    localparam logic [31:0] ANG_PI_4 = 32'h3243F6A9;
    localparam logic [31:0] INV_GAIN = 32'h26DD3B6A;

    function automatic logic [31:0] atan_q30(input logic [5:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                6'd0: r = 32'h3243F6A8;  6'd1: r = 32'h1DAC6705;
                6'd2: r = 32'h0FADBAFC;  6'd3: r = 32'h07F56EA6;
                6'd4: r = 32'h03FEAB76;  6'd5: r = 32'h01FFD55B;
                6'd6: r = 32'h00FFFAAA;  6'd7: r = 32'h007FFF55;
                6'd8: r = 32'h003FFFEA;  6'd9: r = 32'h001FFFFD;
                6'd10: r = 32'h000FFFFF; 6'd11: r = 32'h0007FFFF;
                6'd12: r = 32'h0003FFFF; 6'd13: r = 32'h0001FFFF;
                6'd14: r = 32'h0000FFFF; 6'd15: r = 32'h00007FFF;
                6'd16: r = 32'h00003FFF; 6'd17: r = 32'h00001FFF;
                6'd18: r = 32'h00000FFF; 6'd19: r = 32'h000007FF;
                6'd20: r = 32'h000003FF; 6'd21: r = 32'h000001FF;
                6'd22: r = 32'h000000FF; 6'd23: r = 32'h0000007F;
                6'd24: r = 32'h0000003F; 6'd25: r = 32'h0000001F;
                6'd26: r = 32'h0000000F; 6'd27: r = 32'h00000008;
                6'd28: r = 32'h00000004; 6'd29: r = 32'h00000002;
                6'd30: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction
endpackage

// ===== rtl/concentric_disk_sampler.sv =====
// Concentric disk sampler top level: input stage, divider cell chain,
// angle multiply, CORDIC cell chain and output scaling. Uses cds_pkg and the cells.
// Usage: each s_ request carries rand_u in tdata[15:0] and rand_v in tdata[31:16]
// (unsigned Q0.16). Each m_ request carries point_x in tdata[15:0] and point_y in
// tdata[31:16] (signed Q1.15) on a disk of radius 0.5.
// Throughput is one request per cycle while the output is not stalled. The
// pipeline has FRAC_BITS+1 divider cells, CORDIC_STAGES rotation cells, and
// five further register stages between input and output.
// The whole pipeline advances together; when the receiver stalls with a full
// output register, the pipeline holds and s_tready falls, so nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
`include "concentric_disk_sampler_assert.svh"
module concentric_disk_sampler #(
    parameter int FRAC_BITS = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rand_u [15:0], rand_v [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // point_x [15:0], point_y [31:16]
);
    localparam int FB = FRAC_BITS;
    localparam int NDIV = FB + 1;
    localparam int NC = CORDIC_STAGES;
    localparam int LAT = NDIV + NC + 5;

    logic en;
    logic [LAT-1:0] vld_reg;

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    // Stage 0: conversion and magnitudes.
    logic [FB:0] fu, fv;
    logic signed [FB+1:0] a, b;
    logic [FB:0] ma, mb;
    always_comb begin
        if (FB >= 16) begin
            fu = (FB+1)'(s_tdata[15:0]) << (FB - 16);
            fv = (FB+1)'(s_tdata[31:16]) << (FB - 16);
        end else begin
            fu = (FB+1)'(s_tdata[15:0] >> (16 - FB));
            fv = (FB+1)'(s_tdata[31:16] >> (16 - FB));
        end
        a = $signed({fu, 1'b0}) - $signed((FB+2)'(1) << FB);
        b = $signed({fv, 1'b0}) - $signed((FB+2)'(1) << FB);
        ma = a[FB+1] ? (FB+1)'(-a) : a[FB:0];
        mb = b[FB+1] ? (FB+1)'(-b) : b[FB:0];
    end

    // side bits: [FB+1:0] large value, [FB+2] first, [FB+3] neg, [FB+4] zero
    logic [FB:0]   d_rem [NDIV+1];
    logic [FB:0]   d_den [NDIV+1];
    logic [FB:0]   d_quo [NDIV+1];
    logic [FB+4:0] d_side [NDIV+1];
    logic [FB:0]   ms_reg, ml_reg;
    logic [FB+4:0] side0_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            logic first;
            first = ma > mb;
            ms_reg <= first ? mb : ma;
            ml_reg <= first ? ma : mb;
            side0_reg <= {(a == 0) && (b == 0), a[FB+1] ^ b[FB+1], first,
                          first ? a : b};
        end
    end

    // The chain divides ms<<(FB+1) by ml; dropping the last quotient bit
    // leaves (ms<<FB)/ml.
    assign d_rem[0] = ms_reg;
    assign d_den[0] = ml_reg;
    assign d_quo[0] = '0;
    assign d_side[0] = side0_reg;

    genvar g;
    generate
        for (g = 0; g < NDIV; g++) begin : g_div
            cds_div_cell #(.FB(FB)) u_cell (
                .aclk(aclk), .en(en),
                .rem_in(d_rem[g]),
                .den_in(d_den[g]), .quo_in(d_quo[g]), .side_in(d_side[g]),
                .rem_out(d_rem[g+1]), .den_out(d_den[g+1]), .quo_out(d_quo[g+1]),
                .side_out(d_side[g+1])
            );
        end
    endgenerate

    logic [FB:0] q_fix;
    logic [FB:0] ms_pipe [NDIV+1];
    assign ms_pipe[0] = ms_reg;
    generate
        for (g = 0; g < NDIV; g++) begin : g_msp
            logic [FB:0] r;
            always_ff @(posedge aclk) if (en) r <= ms_pipe[g];
            assign ms_pipe[g+1] = r;
        end
    endgenerate
    assign q_fix = {1'b0, d_quo[NDIV][FB:1]};

    // Stage: angle multiply (quotient times pi/4).
    logic [FB:0] q_reg;
    logic [FB+4:0] side_q_reg;
    logic [FB:0] msq_reg, mlq_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_fix;
            side_q_reg <= d_side[NDIV];
            msq_reg <= ms_pipe[NDIV];
            mlq_reg <= d_den[NDIV];
        end
    end
    logic [FB+32:0] prod_reg;
    logic [FB+4:0] side_p_reg;
    always_ff @(posedge aclk) begin
        logic [FB:0] qq;
        if (en) begin
            qq = (msq_reg >= mlq_reg) ? (FB+1)'(1) << FB : q_reg;
            prod_reg <= (FB+33)'(qq) * (FB+33)'(cds_pkg::ANG_PI_4);
            side_p_reg <= side_q_reg;
        end
    end

    logic signed [33:0] cx [NC+1];
    logic signed [33:0] cy [NC+1];
    logic signed [33:0] cz [NC+1];
    logic [FB+4:0] cside [NC+1];
    logic [33:0] tm;
    assign tm = 34'(prod_reg >> FB);
    assign cx[0] = 34'(cds_pkg::INV_GAIN);
    assign cy[0] = '0;
    assign cz[0] = side_p_reg[FB+3] ? -$signed(tm) : $signed(tm);
    assign cside[0] = side_p_reg;
    generate
        for (g = 0; g < NC; g++) begin : g_cordic
            cds_cordic_cell #(.STAGE(g), .SW(FB+5)) u_cell (
                .aclk(aclk), .en(en),
                .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]), .side_in(cside[g]),
                .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1]),
                .side_out(cside[g+1])
            );
        end
    endgenerate

    // Output multiply stage and rounding stage.
    logic [FB+34:0] mx_reg, my_reg;
    logic sx_reg, sy_reg, zero_reg;
    always_ff @(posedge aclk) begin
        logic signed [FB+1:0] r;
        logic [FB+1:0] mr;
        logic signed [33:0] tx, ty;
        logic [33:0] mtx, mty;
        if (en) begin
            r = $signed(cside[NC][FB+1:0]);
            tx = cside[NC][FB+2] ? cx[NC] : cy[NC];
            ty = cside[NC][FB+2] ? cy[NC] : cx[NC];
            mr = r[FB+1] ? (FB+2)'(-r) : r;
            mtx = tx[33] ? 34'(-tx) : tx;
            mty = ty[33] ? 34'(-ty) : ty;
            mx_reg <= (FB+35)'(mr) * (FB+35)'(mtx);
            my_reg <= (FB+35)'(mr) * (FB+35)'(mty);
            sx_reg <= r[FB+1] ^ tx[33];
            sy_reg <= r[FB+1] ^ ty[33];
            zero_reg <= cside[NC][FB+4];
        end
    end

    logic [31:0] out_reg;
    always_ff @(posedge aclk) begin
        logic [FB+34:0] rx, ry;
        logic [15:0] vx, vy;
        if (en) begin
            rx = (mx_reg + ((FB+35)'(1) << (FB+15))) >> (FB+16);
            ry = (my_reg + ((FB+35)'(1) << (FB+15))) >> (FB+16);
            vx = (rx > 16384) ? 16'd16384 : rx[15:0];
            vy = (ry > 16384) ? 16'd16384 : ry[15:0];
            if (zero_reg) out_reg <= '0;
            else out_reg <= {sy_reg ? -vy : vy, sx_reg ? -vx : vx};
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata = out_reg;

    `CDS_ASSERT_IMPL(a_ready_when_free, aclk, aresetn, !m_tvalid, s_tready)
    `CDS_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `CDS_ASSERT_IMPL(a_range_x, aclk, aresetn, m_tvalid,
        $signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384)
endmodule

// ===== rtl/cds_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per cycle while en is high.
// Depends on nothing but its ports; instantiated by the top level.
module cds_div_cell #(
    parameter int FB = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [FB:0]   rem_in,
    input  logic [FB:0]   den_in,
    input  logic [FB:0]   quo_in,
    input  logic [FB+4:0] side_in,
    output logic [FB:0]   rem_out,
    output logic [FB:0]   den_out,
    output logic [FB:0]   quo_out,
    output logic [FB+4:0] side_out
);
    logic [FB+1:0] sh;
    logic [FB+1:0] diff;
    logic          ge;

    always_comb begin
        sh = {rem_in, 1'b0};
        diff = sh - {1'b0, den_in};
        ge = sh >= {1'b0, den_in};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out  <= ge ? diff[FB:0] : sh[FB:0];
            den_out  <= den_in;
            quo_out  <= {quo_in[FB-1:0], ge};
            side_out <= side_in;
        end
    end
endmodule

// ===== rtl/cds_cordic_cell.sv =====
// One CORDIC rotation cell with a fixed stage index.
// Depends on cds_pkg for the arctangent table.
module cds_cordic_cell #(
    parameter int STAGE = 0,
    parameter int SW = 8
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [33:0] z_in,
    input  logic [SW-1:0]      side_in,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out,
    output logic signed [33:0] z_out,
    output logic [SW-1:0]      side_out
);
    logic signed [33:0] xs, ys, at;

    always_comb begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        at = 34'(cds_pkg::atan_q30(6'(STAGE)));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!z_in[33]) begin
                x_out <= x_in - ys;
                y_out <= y_in + xs;
                z_out <= z_in - at;
            end else begin
                x_out <= x_in + ys;
                y_out <= y_in - xs;
                z_out <= z_in + at;
            end
            side_out <= side_in;
        end
    end
endmodule
